// File: sv/nss_pkg.sv
// Package for the nearest segment search block: widths, command and status types.
// No dependencies.
package nss_pkg;

	localparam int COORD_BITS_DEF = 24;
	localparam int NODES_DEF      = 4096;
	localparam int DIST_W         = 25;
	localparam int PART_W         = 2;
	localparam int SQ_W           = 51;

	localparam logic [PART_W-1:0] PART_INNER  = 2'd0;
	localparam logic [PART_W-1:0] PART_FIRST  = 2'd1;
	localparam logic [PART_W-1:0] PART_SECOND = 2'd2;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// controller to datapath
	typedef struct packed {
		logic load;      // capture request, start product stage
		logic classify;  // pick part, start root
		logic step;      // one iteration of the shared unit
		logic update;    // compare with kept minimum
		logic quarter;   // form min^2/4
		logic root1;     // start first end root
		logic root2;     // start second end root
		logic store1;    // keep first end result
		logic store2;    // keep second end result
		logic clear;     // start new search
	} nss_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic unit_done;
		logic is_last;
	} nss_sts_t;

endpackage

// File: sv/nss_datapath.sv
// Datapath: products, shared iterative root and divide unit, minimum keeping.
// Depends on nss_pkg.
module nss_datapath import nss_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int NODE_W     = $clog2(NODES_DEF)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  nss_cmd_t                     cmd,
	output nss_sts_t                     sts,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic signed [COORD_BITS-1:0] first_x,
	input  logic signed [COORD_BITS-1:0] first_y,
	input  logic signed [COORD_BITS-1:0] second_x,
	input  logic signed [COORD_BITS-1:0] second_y,
	input  logic [NODE_W-1:0]            first_node,
	input  logic [NODE_W-1:0]            second_node,
	input  logic                         last_segment,
	output logic [DIST_W-1:0]            min_distance,
	output logic [NODE_W-1:0]            best_first_node,
	output logic [NODE_W-1:0]            best_second_node,
	output logic [PART_W-1:0]            nearest_part,
	output logic [DIST_W-1:0]            first_end_distance,
	output logic [DIST_W-1:0]            second_end_distance
);
	localparam int DW = COORD_BITS + 1;          // difference width
	localparam int PW = 2 * DW;                  // product width
	localparam int SW = PW + 1;                  // sum of two products
	localparam int UW = 66;                      // radicand / dividend width (even)
	localparam int RW = UW / 2;                  // root width
	localparam int CW = $clog2(UW + 1);          // iteration counter

	// captured differences
	logic signed [DW-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
	logic [NODE_W-1:0]    fn_q, sn_q;
	logic                 last_q;
	// products, two multipliers each
	logic signed [SW-1:0] ab_q, cb_q, sq1_q, sq2_q, len2_q, cr_q;

	// capture request and form differences
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ax_q   <= DW'(first_x) - DW'(point_x);
			ay_q   <= DW'(first_y) - DW'(point_y);
			bx_q   <= DW'(first_x) - DW'(second_x);
			by_q   <= DW'(first_y) - DW'(second_y);
			cx_q   <= DW'(second_x) - DW'(point_x);
			cy_q   <= DW'(second_y) - DW'(point_y);
			fn_q   <= first_node;
			sn_q   <= second_node;
			last_q <= last_segment;
		end
	end

	// products: each sum of two products registered once
	always_ff @(posedge clk) begin
		ab_q   <= SW'(ax_q * bx_q) + SW'(ay_q * by_q);
		cb_q   <= -(SW'(cx_q * bx_q) + SW'(cy_q * by_q));
		sq1_q  <= SW'(ax_q * ax_q) + SW'(ay_q * ay_q);
		sq2_q  <= SW'(cx_q * cx_q) + SW'(cy_q * cy_q);
		len2_q <= SW'(bx_q * bx_q) + SW'(by_q * by_q);
		cr_q   <= SW'(ax_q * cy_q) - SW'(ay_q * cx_q);
	end

	// shared unit: root (mode 0) or restoring division (mode 1)
	logic [UW-1:0] rem_q, op_q;
	logic [RW-1:0] res_q;
	logic [UW-1:0] quo_q, div_q;
	logic [CW-1:0] cnt_q;
	logic          div_mode_q, busy_q, second_q, zero_q;
	logic [PART_W-1:0] cur_part_q;
	logic [DIST_W-1:0] cur_d;
	logic [RW+1:0]  trial;
	logic [RW+2:0]  rem_top;
	logic [UW:0]    drem;

	// distance of current segment, saturated
	always_comb begin
		if (zero_q) begin
			cur_d = '0;
		end else if (div_mode_q) begin
			cur_d = (|quo_q[UW-1:DIST_W]) ? DIST_MAX : quo_q[DIST_W-1:0];
		end else begin
			cur_d = (|res_q[RW-1:DIST_W]) ? DIST_MAX : res_q[DIST_W-1:0];
		end
	end

	logic [DIST_W-1:0] best_d_q;
	logic [NODE_W-1:0] best_f_q, best_s_q;
	logic [PART_W-1:0] best_p_q;
	logic [SQ_W-1:0]   best_sq1_q, best_sq2_q;
	logic              have_q;
	logic [2*DIST_W-1:0] quart_q;
	logic [SQ_W-1:0]   rad;
	logic              neg;

	always_comb begin
		rad = cmd.root1 ? best_sq1_q : best_sq2_q;
		neg = rad < SQ_W'(quart_q);
	end

	// one root digit: rem:op shifted two bits at a time
	assign rem_top = {rem_q[RW:0], op_q[UW-1:UW-2]};
	assign trial   = {res_q, 2'b01};
	assign drem    = {rem_q, quo_q[UW-1]};

	// restart the unit for the division phase
	logic div_start;
	assign div_start = !busy_q && second_q && !div_mode_q && cmd.step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (cmd.classify || cmd.root1 || cmd.root2 || div_start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (cmd.step && busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (div_mode_q ? (cnt_q == CW'(UW - 1)) : (cnt_q == CW'(RW - 1)))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.classify) begin
			zero_q <= 1'b0;
			rem_q  <= '0;
			res_q  <= '0;
			if (ab_q <= 0 && cb_q >= 0) begin
				cur_part_q <= PART_FIRST;
				div_mode_q <= 1'b0;
				op_q       <= UW'(sq1_q);
			end else if (ab_q >= 0 && cb_q <= 0) begin
				cur_part_q <= PART_SECOND;
				div_mode_q <= 1'b0;
				op_q       <= UW'(sq2_q);
			end else begin
				// interior: root of len^2 first, then divide
				cur_part_q <= PART_INNER;
				div_mode_q <= 1'b0;
				op_q       <= UW'(len2_q);
			end
			if (!(ab_q <= 0 && cb_q >= 0) && !(ab_q >= 0 && cb_q <= 0))
				second_q <= 1'b1;
			else
				second_q <= 1'b0;
		end else if (cmd.root1 || cmd.root2) begin
			div_mode_q <= 1'b0;
			second_q   <= 1'b0;
			zero_q     <= neg;
			rem_q      <= '0;
			res_q      <= '0;
			op_q       <= UW'(rad - SQ_W'(quart_q));
		end else if (cmd.step && busy_q) begin
			if (div_mode_q) begin
				if (drem >= {1'b0, div_q}) begin
					rem_q <= UW'(drem - {1'b0, div_q});
					quo_q <= {quo_q[UW-2:0], 1'b1};
				end else begin
					rem_q <= drem[UW-1:0];
					quo_q <= {quo_q[UW-2:0], 1'b0};
				end
			end else begin
				op_q <= {op_q[UW-3:0], 2'b00};
				if ({1'b0, rem_top} >= {2'b0, trial}) begin
					rem_q <= UW'(rem_top - (RW+3)'(trial));
					res_q <= {res_q[RW-2:0], 1'b1};
				end else begin
					rem_q <= UW'(rem_top);
					res_q <= {res_q[RW-2:0], 1'b0};
				end
			end
		end else if (!busy_q && second_q && !div_mode_q && cmd.step) begin
			// root of length done: divide |cross| by it
			second_q   <= 1'b0;
			div_mode_q <= 1'b1;
			zero_q     <= (res_q == '0);
			div_q      <= UW'(res_q);
			rem_q      <= '0;
			quo_q      <= UW'(cr_q < 0 ? -cr_q : cr_q);
		end
	end

	logic busy_d_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) busy_d_q <= 1'b0;
		else         busy_d_q <= div_start;
	end

	assign sts.unit_done = !busy_q && !second_q && !div_start && !busy_d_q;
	assign sts.is_last   = last_q;

	// keep the strictly smallest distance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (cmd.clear) begin
			have_q <= 1'b0;
		end else if (cmd.update) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update && (!have_q || cur_d < best_d_q)) begin
			best_d_q   <= cur_d;
			best_p_q   <= cur_part_q;
			best_f_q   <= fn_q;
			best_s_q   <= sn_q;
			best_sq1_q <= SQ_W'(sq1_q);
			best_sq2_q <= SQ_W'(sq2_q);
		end
		if (cmd.quarter)
			quart_q <= (best_d_q * best_d_q) >> 2;
		if (cmd.store1)
			first_end_distance <= cur_d;
		if (cmd.store2)
			second_end_distance <= cur_d;
	end

	assign min_distance     = best_d_q;
	assign best_first_node  = best_f_q;
	assign best_second_node = best_s_q;
	assign nearest_part     = best_p_q;

`ifndef NO_ASSERTIONS
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && div_mode_q && !zero_q) |-> div_q != '0)
		else $error("division by zero length");
	a_busy_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !(cmd.update || cmd.load))
		else $error("datapath commanded while unit busy");
	a_have_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && !cmd.clear) |=> have_q)
		else $error("minimum not kept");
`endif
endmodule

// File: sv/nss_ctrl.sv
// Controller state machine: sequences products, unit iterations and result.
// Depends on nss_pkg.
module nss_ctrl import nss_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output nss_cmd_t cmd,
	input  nss_sts_t sts
);
	localparam logic [3:0] S_IDLE = 4'd0, S_PROD = 4'd1, S_CLASS = 4'd2,
		S_RUN = 4'd3, S_UPD = 4'd4, S_QUART = 4'd5, S_R1 = 4'd6, S_R1RUN = 4'd7,
		S_R2 = 4'd8, S_R2RUN = 4'd9, S_OUT = 4'd10, S_WAIT = 4'd11;

	logic [3:0] state_q, state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_WAIT;
				end
			end
			S_WAIT:  state_d = S_PROD;
			S_PROD: begin
				cmd.classify = 1'b1;
				state_d      = S_RUN;
			end
			S_CLASS: state_d = S_RUN;
			S_RUN: begin
				cmd.step = 1'b1;
				if (sts.unit_done) state_d = S_UPD;
			end
			S_UPD: begin
				cmd.update = 1'b1;
				state_d    = sts.is_last ? S_QUART : S_IDLE;
			end
			S_QUART: begin
				cmd.quarter = 1'b1;
				state_d     = S_R1;
			end
			S_R1: begin
				cmd.root1 = 1'b1;
				state_d   = S_R1RUN;
			end
			S_R1RUN: begin
				cmd.step = 1'b1;
				if (sts.unit_done) begin
					cmd.store1 = 1'b1;
					state_d    = S_R2;
				end
			end
			S_R2: begin
				cmd.root2 = 1'b1;
				state_d   = S_R2RUN;
			end
			S_R2RUN: begin
				cmd.step = 1'b1;
				if (sts.unit_done) begin
					cmd.store2 = 1'b1;
					state_d    = S_OUT;
				end
			end
			S_OUT: begin
				if (out_ready) begin
					cmd.clear = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

`ifndef NO_ASSERTIONS
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("request taken while result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped");
	a_clear_on_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |-> cmd.clear)
		else $error("search not restarted");
`endif
endmodule

// File: sv/nearest_segment_search.sv
// Top level of the nearest segment search: controller plus datapath.
// Depends on nss_pkg, nss_ctrl, nss_datapath.
//
//  channel | handshake            | payload
//  in      | in_valid / in_ready   | point, endpoints, nodes, last_segment
//  out     | out_valid / out_ready | min_distance, nodes, part, end distances
//
// A segment at an endpoint takes one root of its squared distance; in the
// interior it takes 33 root steps of the squared length, then 66 divide
// steps. One shared iterative root/divide unit does both. A last segment
// adds two more roots before the result. Reset is asynchronous and clears
// the controller and the search. The result holds until taken; no new
// request is taken while it waits.
module nearest_segment_search import nss_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int NODES      = NODES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic signed [COORD_BITS-1:0] first_x,
	input  logic signed [COORD_BITS-1:0] first_y,
	input  logic signed [COORD_BITS-1:0] second_x,
	input  logic signed [COORD_BITS-1:0] second_y,
	input  logic [$clog2(NODES)-1:0]     first_node,
	input  logic [$clog2(NODES)-1:0]     second_node,
	input  logic                         last_segment,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [DIST_W-1:0]            min_distance,
	output logic [$clog2(NODES)-1:0]     best_first_node,
	output logic [$clog2(NODES)-1:0]     best_second_node,
	output logic [PART_W-1:0]            nearest_part,
	output logic [DIST_W-1:0]            first_end_distance,
	output logic [DIST_W-1:0]            second_end_distance
);
	nss_cmd_t cmd;
	nss_sts_t sts;

	nss_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.cmd, .sts
	);

	nss_datapath #(.COORD_BITS(COORD_BITS), .NODE_W($clog2(NODES))) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.point_x, .point_y, .first_x, .first_y, .second_x, .second_y,
		.first_node, .second_node, .last_segment,
		.min_distance, .best_first_node, .best_second_node, .nearest_part,
		.first_end_distance, .second_end_distance
	);
endmodule
